FILE: src/sblt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sblt_pkg
// Shared types, op codes and constants for the stepper, beep and LED
// tick controller.
// ----------------------------------------------------------------------------
package sblt_pkg;

	localparam int DURATION_BITS = 16;
	localparam int STEP_BITS     = 32;

	localparam logic [15:0] DUR_MASK  = (DURATION_BITS >= 16) ? 16'hFFFF :
		16'((32'd1 << DURATION_BITS) - 32'd1);
	localparam logic [31:0] STEP_MASK = (STEP_BITS >= 32) ? 32'hFFFF_FFFF :
		32'((64'd1 << STEP_BITS) - 64'd1);

	typedef enum logic [2:0] {
		OP_TICK       = 3'd0,
		OP_START_MOVE = 3'd1,
		OP_START_BEEP = 3'd2,
		OP_START_LED  = 3'd3,
		OP_LOAD_MS    = 3'd4
	} op_t;

	localparam logic [1:0] MODEL_TWO_PHASE = 2'd0;
	localparam logic [1:0] MODEL_WAVE      = 2'd1;
	localparam logic [1:0] MODEL_FULL      = 2'd2;
	localparam logic [1:0] MODEL_HALF      = 2'd3;

	localparam logic [3:0] COIL_TAB [0:3][0:7] = '{
		'{4'hA, 4'h6, 4'h5, 4'h9, 4'h0, 4'h0, 4'h0, 4'h0},
		'{4'h1, 4'h2, 4'h4, 4'h8, 4'h0, 4'h0, 4'h0, 4'h0},
		'{4'h9, 4'h3, 4'h6, 4'hC, 4'h0, 4'h0, 4'h0, 4'h0},
		'{4'h9, 4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8}
	};

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] step_count;
		logic [7:0]  speed_div;
		logic        clockwise;
		logic [15:0] burst_count;
		logic [15:0] on_time;
		logic [15:0] off_time;
		logic [15:0] tone_freq;
		logic [31:0] ms_value;
	} item_t;

	typedef struct packed {
		logic [3:0]  coils;
		logic        beep_on;
		logic [15:0] beep_freq;
		logic        led_on;
		logic [31:0] steps_left;
		logic [31:0] ms_left;
	} result_t;

	typedef struct packed {
		logic tick;
		logic start;
	} motor_ctrl_t;

	typedef struct packed {
		logic tick;
		logic load;
	} burst_ctrl_t;

endpackage
`default_nettype wire

FILE: src/sblt_motor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sblt_motor
// Speed divider, step counter and coil phase sequencer.
// ----------------------------------------------------------------------------
module sblt_motor (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire sblt_pkg::motor_ctrl_t ctrl,
	input  wire logic [1:0]           motor_model,
	input  wire logic [31:0]          step_count,
	input  wire logic [7:0]           speed_div,
	input  wire logic                 clockwise,
	output logic [3:0]                coils_next,
	output logic [31:0]               steps_next
);

	logic [7:0]         div_q, div_n;
	logic [7:0]         reload_q, reload_n;
	logic [31:0]        steps_q, steps_n;
	logic signed [4:0]  phase_q, phase_n;
	logic               cw_q, cw_n;
	logic [3:0]         coil_q, coil_n;
	logic signed [4:0]  last;

	always_comb begin
		div_n    = div_q;
		reload_n = reload_q;
		steps_n  = steps_q;
		phase_n  = phase_q;
		cw_n     = cw_q;
		coil_n   = coil_q;
		last     = (motor_model == sblt_pkg::MODEL_HALF) ? 5'sd7 : 5'sd3;
		if (ctrl.tick) begin
			div_n = div_q - 8'd1;
			if (div_n == 8'd0) begin
				div_n = reload_q;
				if (steps_q != 32'd0) begin
					if (cw_q) begin
						phase_n = phase_q + 5'sd1;
						if (phase_n > last)
							phase_n = 5'sd0;
					end else begin
						phase_n = phase_q - 5'sd1;
						if (phase_n < 5'sd0)
							phase_n = last;
					end
					// hold the last pattern when the phase is off the table
					if (phase_n >= 5'sd0 && phase_n <= last)
						coil_n = sblt_pkg::COIL_TAB[motor_model][phase_n[2:0]];
					steps_n = steps_q - 32'd1;
				end
				if (steps_n == 32'd0)
					coil_n = 4'h0;
			end
		end else if (ctrl.start) begin
			steps_n  = step_count & sblt_pkg::STEP_MASK;
			reload_n = speed_div;
			div_n    = speed_div;
			cw_n     = clockwise;
			phase_n  = clockwise ? -5'sd1 : 5'sd4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q    <= '0;
			reload_q <= '0;
			steps_q  <= '0;
			phase_q  <= '0;
			cw_q     <= 1'b0;
			coil_q   <= '0;
		end else begin
			div_q    <= div_n;
			reload_q <= reload_n;
			steps_q  <= steps_n;
			phase_q  <= phase_n;
			cw_q     <= cw_n;
			coil_q   <= coil_n;
		end
	end

	assign coils_next = coil_n;
	assign steps_next = steps_n;

endmodule
`default_nettype wire

FILE: src/sblt_burst.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sblt_burst
// Burst generator: repeats on-time / off-time cycles for a given count.
// ----------------------------------------------------------------------------
module sblt_burst (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire sblt_pkg::burst_ctrl_t ctrl,
	input  wire logic [15:0]          burst_count,
	input  wire logic [15:0]          on_time,
	input  wire logic [15:0]          off_time,
	output logic                      out_next
);

	logic [15:0] left_q, left_n;
	logic [15:0] on_len_q, on_len_n;
	logic [15:0] off_len_q, off_len_n;
	logic [15:0] on_tmr_q, on_tmr_n;
	logic [16:0] off_tmr_q, off_tmr_n;
	logic        pausing_q, pausing_n;
	logic        reload_q, reload_n;
	logic        out_q, out_n;

	always_comb begin
		left_n    = left_q;
		on_len_n  = on_len_q;
		off_len_n = off_len_q;
		on_tmr_n  = on_tmr_q;
		off_tmr_n = off_tmr_q;
		pausing_n = pausing_q;
		reload_n  = reload_q;
		out_n     = out_q;
		if (ctrl.tick && left_q != 16'd0) begin
			if (reload_q) begin
				off_tmr_n = {1'b0, off_len_q} + 17'd1;
				on_tmr_n  = on_len_q;
				pausing_n = 1'b0;
				reload_n  = 1'b0;
			end
			if (!pausing_n && on_tmr_n != 16'd0) begin
				out_n    = 1'b1;
				on_tmr_n = on_tmr_n - 16'd1;
				if (on_tmr_n == 16'd0) begin
					out_n     = 1'b0;
					pausing_n = 1'b1;
				end
			end
			if (pausing_n && off_tmr_n != 17'd0) begin
				out_n     = 1'b0;
				off_tmr_n = off_tmr_n - 17'd1;
				if (off_tmr_n == 17'd0) begin
					pausing_n = 1'b0;
					left_n    = left_q - 16'd1;
					reload_n  = 1'b1;
				end
			end
		end else if (ctrl.load) begin
			// running timers keep going until the next cycle reload
			left_n    = burst_count;
			on_len_n  = on_time & sblt_pkg::DUR_MASK;
			off_len_n = off_time & sblt_pkg::DUR_MASK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q    <= '0;
			on_len_q  <= '0;
			off_len_q <= '0;
			on_tmr_q  <= '0;
			off_tmr_q <= '0;
			pausing_q <= 1'b0;
			reload_q  <= 1'b1;
			out_q     <= 1'b0;
		end else begin
			left_q    <= left_n;
			on_len_q  <= on_len_n;
			off_len_q <= off_len_n;
			on_tmr_q  <= on_tmr_n;
			off_tmr_q <= off_tmr_n;
			pausing_q <= pausing_n;
			reload_q  <= reload_n;
			out_q     <= out_n;
		end
	end

	assign out_next = out_n;

endmodule
`default_nettype wire

FILE: src/stepper_beep_led_tick_controller_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stepper_beep_led_tick_controller_core
// Millisecond-tick controller for a unipolar stepper, a tone burst and an
// LED burst.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_ready/item) takes one command word per
//   cycle unless stalled: tick, start move/beeps/blinks or load ms counter.
//   result channel (result_valid/result_ready/result) returns one word per
//   command with the coil pattern, burst outputs and counters after it.
//   cfg_we/cfg_wdata write motor_model; write only while the block is idle.
// Path: a word is captured in the input register at its accepting edge,
//   and its updated state is written to the result register when it
//   advances, which waits while a held result is not yet taken.
// Throughput: one word per cycle when not stalled, set by the single
//   input register feeding one update pass into the result register.
// Reset: all counters, coils and burst outputs go to zero, motor_model to
//   the two-phase table; no word is pending.
// Stall: while result_ready is low the result and the word in the input
//   register hold; item_ready drops once both are occupied.
// ----------------------------------------------------------------------------
module stepper_beep_led_tick_controller_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire sblt_pkg::item_t   item,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output sblt_pkg::result_t      result,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_wdata
);

	sblt_pkg::item_t       item_s1;
	logic                  valid_s1;
	sblt_pkg::result_t     result_s2;
	logic                  valid_s2;
	logic                  advance;
	logic [1:0]            model_q;
	logic [31:0]           ms_q, ms_n;
	logic [15:0]           freq_q, freq_n;
	sblt_pkg::motor_ctrl_t motor_ctrl;
	sblt_pkg::burst_ctrl_t beep_ctrl, led_ctrl;
	logic [3:0]            coils_next;
	logic [31:0]           steps_next;
	logic                  beep_next, led_next;
	logic                  is_tick;

	assign advance    = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid)
			item_s1 <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_q <= sblt_pkg::MODEL_TWO_PHASE;
		end else if (cfg_we) begin
			model_q <= cfg_wdata;
		end
	end

	assign is_tick          = advance && item_s1.op == sblt_pkg::OP_TICK;
	assign motor_ctrl.tick  = is_tick;
	assign motor_ctrl.start = advance && item_s1.op == sblt_pkg::OP_START_MOVE;
	assign beep_ctrl.tick   = is_tick;
	assign beep_ctrl.load   = advance && item_s1.op == sblt_pkg::OP_START_BEEP;
	assign led_ctrl.tick    = is_tick;
	assign led_ctrl.load    = advance && item_s1.op == sblt_pkg::OP_START_LED;

	always_comb begin
		ms_n   = ms_q;
		freq_n = freq_q;
		if (is_tick && ms_q != 32'd0)
			ms_n = ms_q - 32'd1;
		else if (advance && item_s1.op == sblt_pkg::OP_LOAD_MS)
			ms_n = item_s1.ms_value;
		if (beep_ctrl.load)
			freq_n = item_s1.tone_freq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q   <= '0;
			freq_q <= '0;
		end else begin
			ms_q   <= ms_n;
			freq_q <= freq_n;
		end
	end

	sblt_motor u_motor (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (motor_ctrl),
		.motor_model (model_q),
		.step_count  (item_s1.step_count),
		.speed_div   (item_s1.speed_div),
		.clockwise   (item_s1.clockwise),
		.coils_next  (coils_next),
		.steps_next  (steps_next)
	);

	sblt_burst u_beep (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (beep_ctrl),
		.burst_count (item_s1.burst_count),
		.on_time     (item_s1.on_time),
		.off_time    (item_s1.off_time),
		.out_next    (beep_next)
	);

	sblt_burst u_led (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (led_ctrl),
		.burst_count (item_s1.burst_count),
		.on_time     (item_s1.on_time),
		.off_time    (item_s1.off_time),
		.out_next    (led_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// capture the state as it stands after this word's update
	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2.coils      <= coils_next;
			result_s2.beep_on    <= beep_next;
			result_s2.beep_freq  <= freq_n;
			result_s2.led_on     <= led_next;
			result_s2.steps_left <= steps_next;
			result_s2.ms_left    <= ms_n;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

`ifndef NO_ASSERTIONS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> (valid_s1 && valid_s2 && !result_ready))
		else $error("item_ready low without a stalled result");

	a_ms_never_grows: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && item_s1.op == sblt_pkg::OP_LOAD_MS) |=> ms_q <= $past(ms_q))
		else $error("ms counter grew without a load");

	a_result_from_advance: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(advance))
		else $error("result appeared without an update");
`endif

endmodule
`default_nettype wire

FILE: sim/stepper_beep_led_tick_controller_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_beep_led_tick_controller_core_tb
// Drives command words into the tick controller under random source gaps
// and sink stalls. An in-bench model of the stepper, tone burst and LED burst
// predicts every status word, and the status words are checked in order.
// The motor table is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module stepper_beep_led_tick_controller_core_tb;

	localparam int          HALF_PERIOD  = 4;
	localparam int          IDLE_LIMIT   = 2000;
	localparam int          SETTLE_TICKS = 4;
	localparam logic [2:0]  OP_UNUSED_LO = 3'd5;
	localparam logic [2:0]  OP_UNUSED_HI = 3'd7;

	// coil patterns per table, phase 0 in the low nibble
	localparam logic [3:0][31:0] COIL_PATTERNS = {
		32'h8C46_2319, 32'h0000_C639, 32'h0000_8421, 32'h0000_956A
	};

	typedef struct packed {
		logic [15:0] left;
		logic [15:0] on_len;
		logic [15:0] off_len;
		logic [15:0] on_timer;
		logic [16:0] off_timer;
		logic        pausing;
		logic        reload;
		logic        out;
	} burst_t;

	logic                clk;
	logic                arst_n;
	logic                item_valid;
	logic                item_ready;
	sblt_pkg::item_t     item;
	logic                result_valid;
	logic                result_ready;
	sblt_pkg::result_t   result;
	logic                cfg_we;
	logic [1:0]          cfg_wdata;

	// predicted block state
	logic [1:0]  motor_model;
	logic [7:0]  div_count;
	logic [7:0]  div_reload;
	logic [31:0] steps_remaining;
	int          coil_phase;
	logic        turn_cw;
	logic [3:0]  coil_drive;
	logic [31:0] ms_countdown;
	logic [15:0] tone_freq_reg;
	burst_t      tone_burst;
	burst_t      led_burst;

	sblt_pkg::result_t status_q[$];
	sblt_pkg::result_t want;
	int          mismatches;
	int          idle_cycles;
	bit          gaps_on;

	stepper_beep_led_tick_controller_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	function automatic burst_t burst_advance(input burst_t b);
		if (b.left == 16'd0) begin
			return b;
		end
		if (b.reload) begin
			b.off_timer = {1'b0, b.off_len} + 17'd1;
			b.on_timer  = b.on_len;
			b.pausing   = 1'b0;
			b.reload    = 1'b0;
		end
		if (!b.pausing && b.on_timer != 16'd0) begin
			b.out      = 1'b1;
			b.on_timer = b.on_timer - 16'd1;
			if (b.on_timer == 16'd0) begin
				b.out     = 1'b0;
				b.pausing = 1'b1;
			end
		end
		if (b.pausing && b.off_timer != 17'd0) begin
			b.out       = 1'b0;
			b.off_timer = b.off_timer - 17'd1;
			if (b.off_timer == 17'd0) begin
				b.pausing = 1'b0;
				b.left    = b.left - 16'd1;
				b.reload  = 1'b1;
			end
		end
		return b;
	endfunction

	function automatic burst_t burst_start(input burst_t b, input sblt_pkg::item_t w);
		b.left    = w.burst_count;
		b.on_len  = w.on_time & sblt_pkg::DUR_MASK;
		b.off_len = w.off_time & sblt_pkg::DUR_MASK;
		return b;
	endfunction

	function automatic void reset_status_model();
		motor_model     = sblt_pkg::MODEL_TWO_PHASE;
		div_count       = '0;
		div_reload      = '0;
		steps_remaining = '0;
		coil_phase      = 0;
		turn_cw         = 1'b0;
		coil_drive      = '0;
		ms_countdown    = '0;
		tone_freq_reg   = '0;
		tone_burst      = '0;
		tone_burst.reload = 1'b1;
		led_burst       = tone_burst;
	endfunction

	function automatic sblt_pkg::result_t predict_status(input sblt_pkg::item_t w);
		sblt_pkg::result_t r;
		int                last_phase;
		case (w.op)
			sblt_pkg::OP_TICK: begin
				if (ms_countdown != 0) ms_countdown = ms_countdown - 32'd1;
				div_count = div_count - 8'd1;
				if (div_count == 8'd0) begin
					div_count = div_reload;
					if (steps_remaining != 0) begin
						last_phase = (motor_model == sblt_pkg::MODEL_HALF) ? 7 : 3;
						if (turn_cw) begin
							coil_phase++;
							if (coil_phase > last_phase) coil_phase = 0;
						end else begin
							coil_phase--;
							if (coil_phase < 0) coil_phase = last_phase;
						end
						// a phase left over from the half-step table holds the coils
						if (coil_phase <= last_phase)
							coil_drive = COIL_PATTERNS[motor_model][coil_phase*4 +: 4];
						steps_remaining = steps_remaining - 32'd1;
					end
					if (steps_remaining == 0) coil_drive = '0;
				end
				tone_burst = burst_advance(tone_burst);
				led_burst  = burst_advance(led_burst);
			end
			sblt_pkg::OP_START_MOVE: begin
				steps_remaining = w.step_count & sblt_pkg::STEP_MASK;
				div_reload      = w.speed_div;
				div_count       = w.speed_div;
				turn_cw         = w.clockwise;
				coil_phase      = w.clockwise ? -1 : 4;
			end
			sblt_pkg::OP_START_BEEP: begin
				tone_burst    = burst_start(tone_burst, w);
				tone_freq_reg = w.tone_freq;
			end
			sblt_pkg::OP_START_LED: begin
				led_burst = burst_start(led_burst, w);
			end
			sblt_pkg::OP_LOAD_MS: begin
				ms_countdown = w.ms_value;
			end
			default: begin
			end
		endcase
		r.coils      = coil_drive;
		r.beep_on    = tone_burst.out;
		r.beep_freq  = tone_freq_reg;
		r.led_on     = led_burst.out;
		r.steps_left = steps_remaining;
		r.ms_left    = ms_countdown;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_val,
		input logic [31:0] got_val);
		if (exp_val !== got_val) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h",
				$time, name, exp_val, got_val);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (status_q.size() == 0) begin
				$display("%0t: status word with none pending: expected none, actual %p",
					$time, result);
				mismatches++;
			end else begin
				want = status_q.pop_front();
				check_field("coils",      32'(want.coils),     32'(result.coils));
				check_field("beep_on",    32'(want.beep_on),   32'(result.beep_on));
				check_field("beep_freq",  32'(want.beep_freq), 32'(result.beep_freq));
				check_field("led_on",     32'(want.led_on),    32'(result.led_on));
				check_field("steps_left", want.steps_left,     result.steps_left);
				check_field("ms_left",    want.ms_left,        result.ms_left);
			end
		end
	end

	// watchdog: any accepted word on either side restarts the count
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles == IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// sink side: random stalls while gaps are enabled
	initial begin
		result_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (gaps_on && $urandom_range(0, 4) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			result_ready <= 1'b1;
			@(posedge clk);
		end
	end

	task automatic send_word(input sblt_pkg::item_t w);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= w;
		do @(posedge clk); while (!item_ready);
		status_q.push_back(predict_status(w));
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (status_q.size() != 0) @(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic apply_motor_model(input logic [1:0] m);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we    <= 1'b0;
		motor_model = m;
	endtask

	function automatic sblt_pkg::item_t blank_word(input logic [2:0] op);
		sblt_pkg::item_t w;
		w    = '0;
		w.op = op;
		return w;
	endfunction

	task automatic send_ticks(input int n);
		repeat (n) send_word(blank_word(sblt_pkg::OP_TICK));
	endtask

	task automatic test_field_extremes();
		sblt_pkg::item_t w;
		send_ticks(1);
		w = '1;
		w.op = OP_UNUSED_HI;
		send_word(w);
		w.op = OP_UNUSED_LO;
		send_word(w);
		w = blank_word(sblt_pkg::OP_LOAD_MS);
		w.ms_value = '1;
		send_word(w);
		w = blank_word(sblt_pkg::OP_START_MOVE);
		w.step_count = '1;
		w.clockwise  = 1'b1;
		send_word(w);
		send_ticks(1);
		w = blank_word(sblt_pkg::OP_START_BEEP);
		w.burst_count = '1;
		w.on_time     = '1;
		w.off_time    = '1;
		w.tone_freq   = '1;
		send_word(w);
		w.op = sblt_pkg::OP_START_LED;
		send_word(w);
		send_ticks(1);
		// zero count: outputs keep their level
		w = blank_word(sblt_pkg::OP_START_BEEP);
		w.tone_freq = 16'h5555;
		send_word(w);
		w = blank_word(sblt_pkg::OP_START_MOVE);
		w.speed_div = 8'hFF;
		send_word(w);
		w = blank_word(sblt_pkg::OP_LOAD_MS);
		send_word(w);
		send_ticks(1);
	endtask

	task automatic test_burst_corners();
		sblt_pkg::item_t w;
		// zero on-time: the LED burst stalls
		w = blank_word(sblt_pkg::OP_START_LED);
		w.burst_count = 16'd2;
		w.off_time    = 16'd1;
		send_word(w);
		w = blank_word(sblt_pkg::OP_START_BEEP);
		w.burst_count = 16'd2;
		w.on_time     = 16'd2;
		w.off_time    = 16'd1;
		w.tone_freq   = 16'd440;
		send_word(w);
		send_ticks(3);
		// restart while active
		w.burst_count = 16'd1;
		w.on_time     = 16'd1;
		w.off_time    = 16'd0;
		w.tone_freq   = 16'hAAAA;
		send_word(w);
		send_ticks(4);
	endtask

	task automatic test_phase_out_of_table();
		sblt_pkg::item_t w;
		apply_motor_model(sblt_pkg::MODEL_HALF);
		w = blank_word(sblt_pkg::OP_START_MOVE);
		w.step_count = 32'd12;
		w.speed_div  = 8'd1;
		send_word(w);
		send_ticks(6);
		// phase now sits past the end of a four-phase table
		apply_motor_model(sblt_pkg::MODEL_TWO_PHASE);
		send_ticks(4);
	endtask

	function automatic sblt_pkg::item_t random_word();
		sblt_pkg::item_t w;
		int              kind;
		w.op          = sblt_pkg::OP_TICK;
		w.step_count  = $urandom;
		w.speed_div   = 8'($urandom);
		w.clockwise   = 1'($urandom);
		w.burst_count = 16'($urandom);
		w.on_time     = 16'($urandom);
		w.off_time    = 16'($urandom);
		w.tone_freq   = 16'($urandom);
		w.ms_value    = $urandom;
		kind = $urandom_range(0, 99);
		if (kind < 60) begin
			w.op = sblt_pkg::OP_TICK;
		end else if (kind < 72) begin
			w.op = sblt_pkg::OP_START_MOVE;
			if ($urandom_range(0, 7) != 0) w.step_count = $urandom_range(0, 40);
			if ($urandom_range(0, 7) != 0) w.speed_div = 8'($urandom_range(0, 4));
		end else if (kind < 92) begin
			w.op = (kind < 82) ? sblt_pkg::OP_START_BEEP : sblt_pkg::OP_START_LED;
			if ($urandom_range(0, 7) != 0) w.burst_count = 16'($urandom_range(0, 4));
			if ($urandom_range(0, 7) != 0) w.on_time = 16'($urandom_range(0, 5));
			if ($urandom_range(0, 7) != 0) w.off_time = 16'($urandom_range(0, 5));
		end else if (kind < 96) begin
			w.op = sblt_pkg::OP_LOAD_MS;
			if ($urandom_range(0, 3) != 0) w.ms_value = $urandom_range(0, 20);
		end else begin
			w.op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
		end
		return w;
	endfunction

	task automatic test_random_traffic(input int n);
		repeat (n) send_word(random_word());
	endtask

	initial begin
		mismatches  = 0;
		idle_cycles = 0;
		gaps_on     = 1'b1;
		reset_status_model();
		arst_n     <= 1'b0;
		item_valid <= 1'b0;
		item       <= '0;
		cfg_we     <= 1'b0;
		cfg_wdata  <= sblt_pkg::MODEL_TWO_PHASE;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_burst_corners();
		test_phase_out_of_table();

		apply_motor_model(sblt_pkg::MODEL_HALF);
		test_random_traffic(220);
		apply_motor_model(sblt_pkg::MODEL_WAVE);
		test_random_traffic(220);
		apply_motor_model(sblt_pkg::MODEL_TWO_PHASE);
		test_random_traffic(220);
		apply_motor_model(sblt_pkg::MODEL_FULL);
		test_random_traffic(220);
		apply_motor_model(sblt_pkg::MODEL_HALF);
		test_random_traffic(220);

		// back-to-back to close out
		gaps_on = 1'b0;
		apply_motor_model(sblt_pkg::MODEL_FULL);
		test_random_traffic(200);
		drain();

		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

FILE: stepper_beep_led_tick_controller_core.f
src/sblt_pkg.sv
src/sblt_motor.sv
src/sblt_burst.sv
src/stepper_beep_led_tick_controller_core.sv
sim/stepper_beep_led_tick_controller_core_tb.sv
